[rtl/core/iqr_pkg.sv]
// Shared constants and handshake structs for the interquartile range engine.
// No dependencies; imported by iqr_quart and interquartile_range_engine.
`timescale 1ns / 1ps
`default_nettype none

package iqr_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int IQR_W       = SAMPLE_BITS + 1;
    localparam int ACC_W       = SAMPLE_BITS + 2;

    // request from the sequencer to the quartile unit
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
    } t_quart_req;

    // quartile unit read port and result
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] raddr;
        logic              done;
        logic [IQR_W-1:0]  iqr;
    } t_quart_rsp;

endpackage

`default_nettype wire

[rtl/core/iqr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iqr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/iqr_quart.sv]
// Quartile unit: picks hinge positions from the set size, reads four entries
// of the sorted store and accumulates 2*(Q3-Q1). Uses iqr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iqr_quart
    import iqr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_quart_req             i_req,
    input  wire logic [SAMPLE_BITS-1:0] i_rdata,
    output t_quart_rsp                  o_rsp
);

    localparam int POS_W = COUNT_W + 1;

    logic              r_busy;
    logic [2:0]        r_step;
    logic              r_done;
    logic [ADDR_W-1:0] r_addr [4];
    logic signed [ACC_W-1:0] r_acc;

    logic [POS_W-1:0] n_ext;
    logic [POS_W-1:0] pos_a, pos_a2, pos_b, pos_b2;
    logic signed [ACC_W-1:0] rd_ext;

    // 1-based hinge positions; for the even-half case two neighbors each
    always_comb begin
        n_ext = POS_W'(i_req.count);
        unique case (i_req.count[1:0])
            2'd0:    pos_a = n_ext >> 2;
            2'd1:    pos_a = (n_ext + POS_W'(3)) >> 2;
            2'd2:    pos_a = (n_ext + POS_W'(2)) >> 2;
            default: pos_a = (n_ext + POS_W'(1)) >> 2;
        endcase
        if (i_req.count[1:0] == 2'd0) begin
            pos_b  = n_ext - pos_a;
            pos_a2 = pos_a + POS_W'(1);
            pos_b2 = pos_b + POS_W'(1);
        end else begin
            pos_b  = n_ext + POS_W'(1) - pos_a;
            pos_a2 = pos_a;
            pos_b2 = pos_b;
        end
    end

    assign rd_ext = ACC_W'($signed(i_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_addr[0] <= ADDR_W'(pos_a - POS_W'(1));
            r_addr[1] <= ADDR_W'(pos_a2 - POS_W'(1));
            r_addr[2] <= ADDR_W'(pos_b - POS_W'(1));
            r_addr[3] <= ADDR_W'(pos_b2 - POS_W'(1));
        end
        // read data lags the address by one step
        if (r_busy) begin
            unique case (r_step)
                3'd1:    r_acc <= -rd_ext;
                3'd2:    r_acc <= r_acc - rd_ext;
                3'd3:    r_acc <= r_acc + rd_ext;
                3'd4:    r_acc <= r_acc + rd_ext;
                default: r_acc <= r_acc;
            endcase
        end
    end

    always_comb begin
        o_rsp.rd_en = r_busy && (r_step < 3'd4);
        o_rsp.raddr = r_addr[r_step[1:0]];
        o_rsp.done  = r_done;
        o_rsp.iqr   = r_acc[ACC_W-1] ? '0 : r_acc[IQR_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/core/interquartile_range_engine.sv]
// Top level: insertion sequencer over the sorted store, quartile unit, result word.
// Uses iqr_pkg, iqr_ram and iqr_quart.
//
//   channel  | valid   | ready   | payload
//   ---------+---------+---------+--------------------------------------------
//   input    | i_valid | o_ready | i_sample, i_last
//   result   | o_valid | i_ready | o_iqr_doubled, o_sample_count, o_overflow
//
// A word is inserted by walking the store down from the fill point, one entry
// per cycle through the single read port, moving up to fill-count entries up;
// into an empty store it is written directly. A dropped word just sets the drop flag.
// A last word then runs the quartile start, the read steps, done and the result load.
// Reset clears the fill count and drop flag; store contents are not cleared.
// Input is taken while a result waits; only a second result stalls on i_ready.
`timescale 1ns / 1ps
`default_nettype none

module interquartile_range_engine
    import iqr_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_last,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic             [IQR_W-1:0]       o_iqr_doubled,
    output logic             [COUNT_W-1:0]     o_sample_count,
    output logic                               o_overflow
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD     = 6'b000010,
        S_CMP    = 6'b000100,
        S_QSTART = 6'b001000,
        S_QWAIT  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_pos, n_pos;
    logic [COUNT_W-1:0] r_fill, n_fill;
    logic r_drop, n_drop;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic r_last, n_last;
    logic r_out_valid;

    logic                   we, re, load;
    logic [ADDR_W-1:0]      waddr, raddr;
    logic [SAMPLE_BITS-1:0] wdata, rdata;
    logic [COUNT_W-1:0]     pos_m1, pos_m2;
    t_quart_req             qreq;
    t_quart_rsp             qrsp;

    iqr_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    iqr_quart u_quart (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (qreq),
        .i_rdata(rdata),
        .o_rsp  (qrsp)
    );

    assign pos_m1  = r_pos - COUNT_W'(1);
    assign pos_m2  = r_pos - COUNT_W'(2);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_fill     = r_fill;
        n_drop     = r_drop;
        n_x        = r_x;
        n_last     = r_last;
        we         = 1'b0;
        waddr      = r_pos[ADDR_W-1:0];
        wdata      = r_x;
        re         = 1'b0;
        raddr      = pos_m1[ADDR_W-1:0];
        load       = 1'b0;
        qreq.start = 1'b0;
        qreq.count = r_fill;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x    = i_sample;
                    n_last = i_last;
                    if (r_fill == COUNT_W'(MAX_SAMPLES)) begin
                        n_drop  = 1'b1;
                        n_state = i_last ? S_QSTART : S_IDLE;
                    end else begin
                        n_pos   = r_fill;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_fill  = r_fill + COUNT_W'(1);
                    n_state = r_last ? S_QSTART : S_IDLE;
                end else begin
                    re      = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // rdata holds entry r_pos-1; move it up or drop the word in
                we = 1'b1;
                if ($signed(rdata) > r_x) begin
                    wdata = rdata;
                    n_pos = pos_m1;
                    if (pos_m1 != '0) begin
                        re    = 1'b1;
                        raddr = pos_m2[ADDR_W-1:0];
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    n_fill  = r_fill + COUNT_W'(1);
                    n_state = r_last ? S_QSTART : S_IDLE;
                end
            end
            S_QSTART: begin
                qreq.start = 1'b1;
                n_state    = S_QWAIT;
            end
            S_QWAIT: begin
                re    = qrsp.rd_en;
                raddr = qrsp.raddr;
                if (qrsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load    = 1'b1;
                    n_fill  = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_x    <= n_x;
        r_last <= n_last;
        if (load) begin
            o_iqr_doubled  <= qrsp.iqr;
            o_sample_count <= r_fill;
            o_overflow     <= r_drop;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= COUNT_W'(MAX_SAMPLES))
        else $error("fill count above capacity");

    a_no_write_in_quart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qrsp.rd_en |-> !we)
        else $error("store written during quartile reads");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qrsp.done |-> (r_state == S_QWAIT))
        else $error("quartile done outside wait state");

    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_pos != '0))
        else $error("compare with empty lower neighbor");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_fill == '0) && o_valid)
        else $error("result load did not clear the set");
`endif

endmodule

`default_nettype wire
